### rtl/text_console_writer_unit_macros.svh
// Assertion macros for the text console writer.
// Used by the sequencer; expects clk and arst_n in the including scope.
`ifndef TEXT_CONSOLE_WRITER_UNIT_MACROS_SVH
`define TEXT_CONSOLE_WRITER_UNIT_MACROS_SVH

// same-cycle implication, held off during reset
`define TCW_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, held off during reset
`define TCW_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### rtl/tcw_pkg.sv
// Shared constants, types and address helpers for the text console writer.
// No dependencies.
package tcw_pkg;

	localparam int COLUMNS  = 80;
	localparam int ROWS     = 24;
	localparam int TAB_SH   = 3;
	localparam int TAB_STOP = 1 << TAB_SH;
	localparam int CELLS    = COLUMNS * ROWS;
	localparam int ADDR_W   = $clog2(CELLS);
	localparam int ROW_W    = 5;
	localparam int COL_W    = 7;
	localparam int CNT_W    = TAB_SH + 1;

	localparam logic       OP_PUT     = 1'b0;
	localparam logic       OP_READ    = 1'b1;
	localparam logic [7:0] CODE_CR    = 8'd13;
	localparam logic [7:0] CODE_LF    = 8'd10;
	localparam logic [7:0] CODE_TAB   = 8'd9;
	localparam logic [7:0] CODE_BS    = 8'd8;
	localparam logic [7:0] CODE_SPACE = 8'd32;
	localparam logic [7:0] ATTR_RESET = 8'd2;

	typedef struct packed {
		logic              we;
		logic [ADDR_W-1:0] addr;
		logic [15:0]       wdata;
	} ram_req_t;

	typedef struct packed {
		logic [7:0]       cell_char;
		logic [7:0]       cell_attr;
		logic [ROW_W-1:0] row;
		logic [COL_W-1:0] col;
	} res_t;

	// logical row to physical row of the circular screen store
	function automatic logic [ROW_W-1:0] phys_row(input logic [ROW_W-1:0] lrow,
			input logic [ROW_W-1:0] top);
		logic [ROW_W:0] s;
		s = {1'b0, lrow} + {1'b0, top};
		if (s >= (ROW_W+1)'(ROWS))
			s = s - (ROW_W+1)'(ROWS);
		return s[ROW_W-1:0];
	endfunction

	function automatic logic [ADDR_W-1:0] cell_addr(input logic [ROW_W-1:0] prow,
			input logic [COL_W-1:0] col);
		return ADDR_W'(ADDR_W'(prow) * ADDR_W'(COLUMNS) + ADDR_W'(col));
	endfunction

endpackage

### rtl/tcw_screen_ram.sv
// Screen cell store: one port, write or read per cycle, registered read data.
// Depends on tcw_pkg.
module tcw_screen_ram (
	input  logic             clk,
	input  tcw_pkg::ram_req_t req,
	output logic [15:0]      rdata
);
	import tcw_pkg::*;

	logic [15:0] mem [CELLS];

	always_ff @(posedge clk) begin
		if (req.we)
			mem[req.addr] <= req.wdata;
		rdata <= mem[req.addr];
	end

endmodule

### rtl/tcw_sequencer.sv
// Sequencer: cursor, scroll offset, attribute register and the cell write loop.
// Depends on tcw_pkg and text_console_writer_unit_macros.svh.
`include "text_console_writer_unit_macros.svh"

module tcw_sequencer (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_stall,
	input  logic                      operation,
	input  logic [7:0]                char_code,
	input  logic [tcw_pkg::ROW_W-1:0] read_row,
	input  logic [tcw_pkg::COL_W-1:0] read_col,
	input  logic                      attr_we,
	input  logic [7:0]                attr_wdata,
	output tcw_pkg::ram_req_t         ram_req,
	input  logic [15:0]               ram_rdata,
	input  logic                      out_free,
	output logic                      res_valid,
	output tcw_pkg::res_t             res
);
	import tcw_pkg::*;

	typedef enum logic [6:0] {
		ST_INIT   = 7'b0000001,
		ST_IDLE   = 7'b0000010,
		ST_READ   = 7'b0000100,
		ST_PUT    = 7'b0001000,
		ST_BS     = 7'b0010000,
		ST_SCROLL = 7'b0100000,
		ST_DONE   = 7'b1000000
	} state_t;

	state_t           state_q;
	logic [ROW_W-1:0] cur_row_q;
	logic [COL_W-1:0] cur_col_q;
	logic [ROW_W-1:0] top_q;
	logic [ROW_W-1:0] clr_row_q;
	logic [COL_W-1:0] clr_col_q;
	logic [CNT_W-1:0] put_cnt_q;
	logic [7:0]       attr_q;
	logic [7:0]       wr_char_q;
	logic [15:0]      cell_q;
	logic             rd_ok_q;

	logic             rd_ok;
	logic             accept;
	logic [ROW_W-1:0] top_next;

	assign accept   = in_valid && (state_q == ST_IDLE);
	assign in_stall = (state_q != ST_IDLE);
	assign rd_ok    = (read_row < ROW_W'(ROWS)) && (read_col < COL_W'(COLUMNS));
	assign top_next = (top_q == ROW_W'(ROWS - 1)) ? '0 : top_q + 1'b1;

	always_comb begin
		ram_req = '0;
		case (state_q)
			ST_IDLE: begin
				if (rd_ok)
					ram_req.addr = cell_addr(phys_row(read_row, top_q), read_col);
			end
			ST_PUT, ST_BS: begin
				ram_req.we    = 1'b1;
				ram_req.addr  = cell_addr(phys_row(cur_row_q, top_q), cur_col_q);
				ram_req.wdata = {attr_q, wr_char_q};
			end
			ST_INIT, ST_SCROLL: begin
				ram_req.we   = 1'b1;
				ram_req.addr = cell_addr(clr_row_q, clr_col_q);
			end
			default: ;
		endcase
	end

	assign res_valid     = (state_q == ST_DONE) && out_free;
	assign res.cell_char = cell_q[7:0];
	assign res.cell_attr = cell_q[15:8];
	assign res.row       = cur_row_q;
	assign res.col       = cur_col_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_INIT;
			cur_row_q <= '0;
			cur_col_q <= '0;
			top_q     <= '0;
			clr_row_q <= '0;
			clr_col_q <= '0;
			put_cnt_q <= '0;
			attr_q    <= ATTR_RESET;
		end else begin
			if (attr_we)
				attr_q <= attr_wdata;
			case (state_q)
				ST_INIT: begin
					// clearing pass over every row after reset
					if (clr_col_q == COL_W'(COLUMNS - 1)) begin
						clr_col_q <= '0;
						if (clr_row_q == ROW_W'(ROWS - 1)) begin
							clr_row_q <= '0;
							state_q   <= ST_IDLE;
						end else begin
							clr_row_q <= clr_row_q + 1'b1;
						end
					end else begin
						clr_col_q <= clr_col_q + 1'b1;
					end
				end
				ST_IDLE: begin
					if (accept) begin
						if (operation == OP_READ) begin
							state_q <= ST_READ;
						end else begin
							case (char_code)
								CODE_CR: state_q <= ST_DONE;
								CODE_LF: begin
									cur_col_q <= '0;
									if (cur_row_q == ROW_W'(ROWS - 1)) begin
										put_cnt_q <= '0;
										top_q     <= top_next;
										clr_row_q <= top_q;
										clr_col_q <= '0;
										state_q   <= ST_SCROLL;
									end else begin
										cur_row_q <= cur_row_q + 1'b1;
										state_q   <= ST_DONE;
									end
								end
								CODE_TAB: begin
									put_cnt_q <= CNT_W'(TAB_STOP) -
										CNT_W'(cur_col_q[TAB_SH-1:0]);
									state_q   <= ST_PUT;
								end
								CODE_BS: begin
									if (cur_col_q != '0) begin
										cur_col_q <= cur_col_q - 1'b1;
									end else if (cur_row_q != '0) begin
										cur_row_q <= cur_row_q - 1'b1;
										cur_col_q <= COL_W'(COLUMNS - 1);
									end
									state_q <= ST_BS;
								end
								default: begin
									put_cnt_q <= CNT_W'(1);
									state_q   <= ST_PUT;
								end
							endcase
						end
					end
				end
				ST_READ: state_q <= ST_DONE;
				ST_PUT: begin
					put_cnt_q <= put_cnt_q - 1'b1;
					if (cur_col_q == COL_W'(COLUMNS - 1)) begin
						cur_col_q <= '0;
						if (cur_row_q == ROW_W'(ROWS - 1)) begin
							// past the last cell: rotate the top row, clear the new bottom
							top_q     <= top_next;
							clr_row_q <= top_q;
							clr_col_q <= '0;
							state_q   <= ST_SCROLL;
						end else begin
							cur_row_q <= cur_row_q + 1'b1;
							state_q   <= (put_cnt_q == CNT_W'(1)) ? ST_DONE : ST_PUT;
						end
					end else begin
						cur_col_q <= cur_col_q + 1'b1;
						state_q   <= (put_cnt_q == CNT_W'(1)) ? ST_DONE : ST_PUT;
					end
				end
				ST_BS: state_q <= ST_DONE;
				ST_SCROLL: begin
					if (clr_col_q == COL_W'(COLUMNS - 1)) begin
						clr_col_q <= '0;
						state_q   <= (put_cnt_q != '0) ? ST_PUT : ST_DONE;
					end else begin
						clr_col_q <= clr_col_q + 1'b1;
					end
				end
				ST_DONE: begin
					if (out_free)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			rd_ok_q   <= rd_ok && (operation == OP_READ);
			cell_q    <= '0;
			wr_char_q <= (char_code == CODE_TAB || char_code == CODE_BS) ?
				CODE_SPACE : char_code;
		end else if (state_q == ST_READ) begin
			cell_q <= rd_ok_q ? ram_rdata : '0;
		end
	end

	`TCW_ASSERT_IMP(a_cursor_range, 1'b1,
		(cur_row_q < ROW_W'(ROWS)) && (cur_col_q < COL_W'(COLUMNS)),
		"cursor outside the screen")
	`TCW_ASSERT_IMP(a_top_range, 1'b1, top_q < ROW_W'(ROWS), "scroll offset out of range")
	`TCW_ASSERT_IMP(a_no_idle_write, (state_q == ST_IDLE) || (state_q == ST_DONE),
		!ram_req.we, "cell write outside a write state")
	`TCW_ASSERT_NXT(a_result_to_idle, res_valid, state_q == ST_IDLE,
		"result beat not followed by idle")

endmodule

### rtl/text_console_writer_unit.sv
// Text console writer top level: sequencer, screen store and output register.
// Depends on tcw_pkg, tcw_sequencer and tcw_screen_ram.
//
//  channel | beat signals          | payload
//  in      | in_valid / in_stall   | operation, char_code, read_row, read_col
//  out     | out_valid / out_stall | cell_char, cell_attr, cursor_row, cursor_col
//  attr    | attr_we               | attr_wdata
//
// After reset the screen store is cleared with in_stall high.
// Tab writes n spaces (1 to 8). Scroll (LF on the last row, or a write past the
// last cell) clears the new bottom row. The one-port store takes one cell per cycle.
// A pending result beat may sit in the output register while the next beat is
// taken; the sequencer holds its result until that register is free.
module text_console_writer_unit (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_stall,
	input  logic                      operation,
	input  logic [7:0]                char_code,
	input  logic [tcw_pkg::ROW_W-1:0] read_row,
	input  logic [tcw_pkg::COL_W-1:0] read_col,
	input  logic                      attr_we,
	input  logic [7:0]                attr_wdata,
	output logic                      out_valid,
	input  logic                      out_stall,
	output logic [7:0]                cell_char,
	output logic [7:0]                cell_attr,
	output logic [tcw_pkg::ROW_W-1:0] cursor_row,
	output logic [tcw_pkg::COL_W-1:0] cursor_col
);
	import tcw_pkg::*;

	ram_req_t    ram_req;
	logic [15:0] ram_rdata;
	logic        out_free;
	logic        res_valid;
	res_t        res;
	logic        out_valid_q;
	res_t        out_q;

	assign out_free = !out_valid_q || !out_stall;

	tcw_sequencer u_seq (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.operation  (operation),
		.char_code  (char_code),
		.read_row   (read_row),
		.read_col   (read_col),
		.attr_we    (attr_we),
		.attr_wdata (attr_wdata),
		.ram_req    (ram_req),
		.ram_rdata  (ram_rdata),
		.out_free   (out_free),
		.res_valid  (res_valid),
		.res        (res)
	);

	tcw_screen_ram u_ram (
		.clk   (clk),
		.req   (ram_req),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_valid) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid)
			out_q <= res;
	end

	assign out_valid  = out_valid_q;
	assign cell_char  = out_q.cell_char;
	assign cell_attr  = out_q.cell_attr;
	assign cursor_row = out_q.row;
	assign cursor_col = out_q.col;

endmodule
